[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the blitter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check, also active during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ccksb_pkg.sv]
// ----------------------------------------------------------------------------
// ccksb_pkg
// Types and constants of the clipped chroma-key sprite blitter.
// ----------------------------------------------------------------------------
package ccksb_pkg;

  localparam int CoordBits   = 12;
  localparam int RectBits    = 4 * CoordBits;
  localparam int OffsetBits  = CoordBits + 1;
  localparam int PosBits     = CoordBits + 2;
  localparam int ColorBits   = 32;
  localparam int ChanBits    = 8;
  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = RectBits;

  localparam int PixBits     = 2 * CoordBits + 2 * ColorBits;
  localparam int InDataBits  = ((PixBits + 7) / 8) * 8;
  localparam int ResBits     = 2 * CoordBits + ColorBits;
  localparam int OutDataBits = ((ResBits + 7) / 8) * 8;

  localparam logic [CfgAddrBits-1:0] RegSourceRect = CfgAddrBits'(0);
  localparam logic [CfgAddrBits-1:0] RegClipRect   = CfgAddrBits'(1);
  localparam logic [CfgAddrBits-1:0] RegOffsetX    = CfgAddrBits'(2);
  localparam logic [CfgAddrBits-1:0] RegOffsetY    = CfgAddrBits'(3);
  localparam logic [CfgAddrBits-1:0] RegChromaKey  = CfgAddrBits'(4);
  localparam logic [CfgAddrBits-1:0] RegSubstColor = CfgAddrBits'(5);
  localparam logic [CfgAddrBits-1:0] RegBlitMode   = CfgAddrBits'(6);

  typedef enum logic [1:0] {
    ModeCopy  = 2'd0,
    ModeKey   = 2'd1,
    ModeSubst = 2'd2,
    ModeGhost = 2'd3
  } mode_t;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic signed [PosBits-1:0] pos_t;
  typedef logic [ColorBits-1:0]      color_t;

  typedef struct packed {
    coord_t bottom;
    coord_t right;
    coord_t top;
    coord_t left;
  } rect_t;

  typedef struct packed {
    rect_t                        src_rect;
    rect_t                        clip_rect;
    logic signed [OffsetBits-1:0] off_x;
    logic signed [OffsetBits-1:0] off_y;
    color_t                       key;
    color_t                       subst;
    mode_t                        mode;
  } cfg_t;

  typedef struct packed {
    color_t dst_color;
    color_t src_color;
    coord_t src_y;
    coord_t src_x;
  } pix_t;

  typedef struct packed {
    pos_t   dx;
    pos_t   dy;
    logic   src_in;
    logic   keyed;
    color_t color;
  } geo_t;

  typedef struct packed {
    logic   we;
    coord_t dest_x;
    coord_t dest_y;
    color_t color;
  } clip_t;

  typedef struct packed {
    color_t color;
    coord_t dest_y;
    coord_t dest_x;
  } res_t;

endpackage

[src/ccksb_cfg.sv]
// ----------------------------------------------------------------------------
// ccksb_cfg
// Configuration register file, write-only, all registers reset to zero.
// ----------------------------------------------------------------------------
module ccksb_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ccksb_pkg::CfgAddrBits-1:0]   cfg_addr,
  input  logic [ccksb_pkg::CfgDataBits-1:0]   cfg_wdata,
  output ccksb_pkg::cfg_t                     cfg
);

  ccksb_pkg::cfg_t cfg_r;
  ccksb_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        ccksb_pkg::RegSourceRect: cfg_nxt.src_rect  = ccksb_pkg::rect_t'(cfg_wdata);
        ccksb_pkg::RegClipRect:   cfg_nxt.clip_rect = ccksb_pkg::rect_t'(cfg_wdata);
        ccksb_pkg::RegOffsetX:    cfg_nxt.off_x = cfg_wdata[ccksb_pkg::OffsetBits-1:0];
        ccksb_pkg::RegOffsetY:    cfg_nxt.off_y = cfg_wdata[ccksb_pkg::OffsetBits-1:0];
        ccksb_pkg::RegChromaKey:  cfg_nxt.key   = cfg_wdata[ccksb_pkg::ColorBits-1:0];
        ccksb_pkg::RegSubstColor: cfg_nxt.subst = cfg_wdata[ccksb_pkg::ColorBits-1:0];
        ccksb_pkg::RegBlitMode:   cfg_nxt.mode  = ccksb_pkg::mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/ccksb_geo.sv]
// ----------------------------------------------------------------------------
// ccksb_geo
// Stage 1: destination arithmetic, source rectangle test, key match and
// colour selection.
// ----------------------------------------------------------------------------
module ccksb_geo (
  input  logic              clk,
  input  logic              rst_n,
  input  ccksb_pkg::cfg_t   cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  ccksb_pkg::pix_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ccksb_pkg::geo_t   dn_data
);

  logic            valid_r;
  ccksb_pkg::geo_t data_r;
  ccksb_pkg::geo_t data_nxt;
  logic            load;

  ccksb_pkg::pos_t sx_ext;
  ccksb_pkg::pos_t sy_ext;
  ccksb_pkg::pos_t offx_ext;
  ccksb_pkg::pos_t offy_ext;
  ccksb_pkg::pos_t sl_ext;
  ccksb_pkg::pos_t st_ext;
  logic [ccksb_pkg::ChanBits:0] sum_r;
  logic [ccksb_pkg::ChanBits:0] sum_g;
  logic [ccksb_pkg::ChanBits:0] sum_b;

  assign load = !valid_r || dn_ready;

  always_comb begin
    sx_ext   = $signed({2'b00, up_data.src_x});
    sy_ext   = $signed({2'b00, up_data.src_y});
    sl_ext   = $signed({2'b00, cfg.src_rect.left});
    st_ext   = $signed({2'b00, cfg.src_rect.top});
    offx_ext = $signed({cfg.off_x[ccksb_pkg::OffsetBits-1], cfg.off_x});
    offy_ext = $signed({cfg.off_y[ccksb_pkg::OffsetBits-1], cfg.off_y});

    sum_r = {1'b0, up_data.dst_color[23:16]} + {1'b0, up_data.src_color[23:16]};
    sum_g = {1'b0, up_data.dst_color[15:8]}  + {1'b0, up_data.src_color[15:8]};
    sum_b = {1'b0, up_data.dst_color[7:0]}   + {1'b0, up_data.src_color[7:0]};

    data_nxt.dx = sx_ext + offx_ext - sl_ext;
    data_nxt.dy = sy_ext + offy_ext - st_ext;
    data_nxt.src_in = (up_data.src_x >= cfg.src_rect.left) &&
                      (up_data.src_x <  cfg.src_rect.right) &&
                      (up_data.src_y >= cfg.src_rect.top) &&
                      (up_data.src_y <  cfg.src_rect.bottom);
    data_nxt.keyed = (cfg.mode != ccksb_pkg::ModeCopy) && (up_data.src_color == cfg.key);

    unique case (cfg.mode)
      ccksb_pkg::ModeCopy,
      ccksb_pkg::ModeKey:   data_nxt.color = up_data.src_color;
      ccksb_pkg::ModeSubst: data_nxt.color = cfg.subst;
      ccksb_pkg::ModeGhost: data_nxt.color = {8'h00, sum_r[ccksb_pkg::ChanBits:1],
                                              sum_g[ccksb_pkg::ChanBits:1],
                                              sum_b[ccksb_pkg::ChanBits:1]};
      default:              data_nxt.color = up_data.src_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign up_ready = load;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/ccksb_clip.sv]
// ----------------------------------------------------------------------------
// ccksb_clip
// Stage 2: clip rectangle test on the signed destination, write decision.
// ----------------------------------------------------------------------------
module ccksb_clip (
  input  logic              clk,
  input  logic              rst_n,
  input  ccksb_pkg::cfg_t   cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  ccksb_pkg::geo_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ccksb_pkg::clip_t  dn_data
);

  logic             valid_r;
  ccksb_pkg::clip_t data_r;
  ccksb_pkg::clip_t data_nxt;
  logic             load;
  logic             dst_in;

  assign load = !valid_r || dn_ready;

  always_comb begin
    dst_in = (up_data.dx >= $signed({2'b00, cfg.clip_rect.left})) &&
             (up_data.dx <  $signed({2'b00, cfg.clip_rect.right})) &&
             (up_data.dy >= $signed({2'b00, cfg.clip_rect.top})) &&
             (up_data.dy <  $signed({2'b00, cfg.clip_rect.bottom}));
    data_nxt.we     = up_data.src_in && dst_in && !up_data.keyed;
    data_nxt.dest_x = up_data.dx[ccksb_pkg::CoordBits-1:0];
    data_nxt.dest_y = up_data.dy[ccksb_pkg::CoordBits-1:0];
    data_nxt.color  = up_data.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign up_ready = load;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/ccksb_out.sv]
// ----------------------------------------------------------------------------
// ccksb_out
// Stage 3: output register; payload forced to zero for skipped pixels.
// ----------------------------------------------------------------------------
module ccksb_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  ccksb_pkg::clip_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic              dn_we,
  output ccksb_pkg::res_t   dn_data
);

  logic            valid_r;
  logic            we_r;
  ccksb_pkg::res_t data_r;
  ccksb_pkg::res_t data_nxt;
  logic            load;

  assign load = !valid_r || dn_ready;

  always_comb begin
    if (up_data.we) begin
      data_nxt.dest_x = up_data.dest_x;
      data_nxt.dest_y = up_data.dest_y;
      data_nxt.color  = up_data.color;
    end else begin
      data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      we_r   <= up_data.we;
      data_r <= data_nxt;
    end
  end

  assign up_ready = load;
  assign dn_valid = valid_r;
  assign dn_we    = we_r;
  assign dn_data  = data_r;

endmodule

[src/clipped_chroma_key_sprite_blit.sv]
// Pipeline: three register stages (geo, clip, out) from input beat to output beat.
// Throughput: one pixel per cycle while out_tready is high; each stage holds
// its beat while downstream stalls, so a stalled output backs up stage by stage.
// Reset: synchronous active-low rst_n empties the pipeline and clears all
// configuration registers to zero.
// ----------------------------------------------------------------------------
// clipped_chroma_key_sprite_blit
// Per-pixel clipped sprite blitter with copy, chroma key, substitute and
// ghost blend modes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_chroma_key_sprite_blit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ccksb_pkg::CfgAddrBits-1:0]   cfg_addr,
  input  logic [ccksb_pkg::CfgDataBits-1:0]   cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // src_x, src_y, src_color, dst_color (from bit 0 up)
  input  logic [ccksb_pkg::InDataBits-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // dest_x, dest_y, out_color (from bit 0 up)
  output logic [ccksb_pkg::OutDataBits-1:0]   out_tdata,
  // write_enable
  output logic                                out_tuser
);

  ccksb_pkg::cfg_t  cfg;
  ccksb_pkg::pix_t  pix;
  ccksb_pkg::geo_t  s1_data;
  ccksb_pkg::clip_t s2_data;
  ccksb_pkg::res_t  res;
  logic             s1_valid;
  logic             s1_ready;
  logic             s2_valid;
  logic             s2_ready;

  assign pix = ccksb_pkg::pix_t'(in_tdata[ccksb_pkg::PixBits-1:0]);

  ccksb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ccksb_geo u_geo (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (pix),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  ccksb_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  ccksb_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_we    (out_tuser),
    .dn_data  (res)
  );

  assign out_tdata = ccksb_pkg::OutDataBits'(res);

  // skipped pixel carries an all-zero payload
  `ASSERT_CLK(a_skip_zero, (out_tvalid && !out_tuser) |-> (out_tdata == '0), "skipped beat not zero")
  // a free output frees the whole ready chain
  `ASSERT_CLK(a_ready_chain, out_tready |-> in_tready, "ready chain broken")
  // accepted beat lands in stage 1
  `ASSERT_CLK(a_accept_s1, (in_tvalid && in_tready) |=> s1_valid, "accepted beat lost")

endmodule
